// File: design/plst_pkg.sv
// ----------------------------------------------------------------------------
// plst_pkg
// Shared types, codes and defaults of the positional list store.
// ----------------------------------------------------------------------------
`default_nettype none

package plst_pkg;

	localparam int DEPTH_DEFAULT     = 16;
	localparam int WORD_BITS_DEFAULT = 32;

	// Wide enough for an index or a count at the largest supported depth (64)
	localparam int CNT_BITS = 7;

	// Requested actions
	localparam logic [2:0] ACT_INSERT   = 3'd0;
	localparam logic [2:0] ACT_REMOVE   = 3'd1;
	localparam logic [2:0] ACT_READ     = 3'd2;
	localparam logic [2:0] ACT_CLEAR    = 3'd3;
	localparam logic [2:0] ACT_TRAVERSE = 3'd4;

	// Result status
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;
	localparam logic [1:0] ST_EMPTY = 2'd3;

	// Operations broadcast along the chain of cells
	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD   = 2'd0;
	localparam cell_op_t CELL_INSERT = 2'd1;
	localparam cell_op_t CELL_REMOVE = 2'd2;
	localparam cell_op_t CELL_ROTATE = 2'd3;

	typedef struct packed {
		cell_op_t              op;
		logic [CNT_BITS-1:0]   pos;
		logic [CNT_BITS-1:0]   cnt;
	} cell_cmd_t;

endpackage

`default_nettype wire

// File: design/plst_cell.sv
// ----------------------------------------------------------------------------
// plst_cell
// One list slot: holds one word, loads the new word on insert and takes a neighbour's or the head's word on shifts.
// ----------------------------------------------------------------------------
`default_nettype none

module plst_cell #(
	parameter int WORD_BITS = plst_pkg::WORD_BITS_DEFAULT,
	parameter int IDX       = 0
) (
	input  wire                          clk,
	input  plst_pkg::cell_cmd_t          cmd,
	input  wire         [WORD_BITS-1:0]  value_in,
	input  wire         [WORD_BITS-1:0]  below,
	input  wire         [WORD_BITS-1:0]  above,
	input  wire         [WORD_BITS-1:0]  head,
	output logic        [WORD_BITS-1:0]  value,
	output logic        [WORD_BITS-1:0]  hit_value
);

	localparam logic [plst_pkg::CNT_BITS-1:0] MY_IDX  = plst_pkg::CNT_BITS'(IDX);
	localparam logic [plst_pkg::CNT_BITS-1:0] NXT_IDX = plst_pkg::CNT_BITS'(IDX + 1);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] word_d;

	always_comb begin
		word_d = word_q;
		unique case (cmd.op)
			plst_pkg::CELL_INSERT: begin
				if (MY_IDX == cmd.pos) begin
					word_d = value_in;
				end else if (MY_IDX > cmd.pos && MY_IDX <= cmd.cnt) begin
					word_d = below;
				end
			end
			plst_pkg::CELL_REMOVE: begin
				if (MY_IDX >= cmd.pos && NXT_IDX < cmd.cnt) begin
					word_d = above;
				end
			end
			plst_pkg::CELL_ROTATE: begin
				if (NXT_IDX == cmd.cnt) begin
					word_d = head;
				end else if (NXT_IDX < cmd.cnt) begin
					word_d = above;
				end
			end
			default: begin
				word_d = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	assign value     = word_q;
	assign hit_value = (MY_IDX == cmd.pos) ? word_q : '0;

endmodule

`default_nettype wire

// File: design/positional_list_store.sv
// ----------------------------------------------------------------------------
// positional_list_store
// Bounded ordered list of signed words held in a chain of shifting cells.
// ----------------------------------------------------------------------------
//
//   channel | handshake          | fields
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_stall  | action, position, value_in
//   out     | out_valid/out_stall| value_out, status, entry_count, last
//
// Insert, remove, read, clear and error cases load their result into the
// output register at the edge that accepts the transfer. Traverse streams
// one result per entry: the chain rotates once per result, streaming the
// head cell, so after count rotations the order is restored. Reset clears
// the entry count and the valid flag; cell contents and the result payload
// stay undefined until written. A stalled result holds the input stalled too.
// ----------------------------------------------------------------------------
`default_nettype none

module positional_list_store #(
	parameter int DEPTH     = plst_pkg::DEPTH_DEFAULT,
	parameter int WORD_BITS = plst_pkg::WORD_BITS_DEFAULT
) (
	input  wire                 clk,
	input  wire                 arst_n,

	input  wire                 in_valid,
	output logic                in_stall,
	input  wire         [2:0]   action,
	input  wire         [3:0]   position,
	input  wire  signed [31:0]  value_in,

	output logic                out_valid,
	input  wire                 out_stall,
	output logic signed [31:0]  value_out,
	output logic        [1:0]   status,
	output logic        [4:0]   entry_count,
	output logic                last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = plst_pkg::CNT_BITS;

	// Chain of cells
	plst_pkg::cell_cmd_t  cmd;
	logic [WORD_BITS-1:0] cell_val [DEPTH];
	logic [WORD_BITS-1:0] cell_hit [DEPTH];
	logic [WORD_BITS-1:0] store_word;
	logic [WORD_BITS-1:0] read_word;

	// Control
	logic          accept;
	logic          out_free;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic          trav_busy_q;
	logic          trav_busy_d;
	logic [CW-1:0] trav_idx_q;
	logic [CW-1:0] trav_idx_d;
	logic [XW-1:0] pos_x;
	logic [XW-1:0] cnt_x;

	// Result register
	logic               out_valid_q;
	logic               out_valid_d;
	logic signed [31:0] value_q;
	logic signed [31:0] value_d;
	logic        [1:0]  status_q;
	logic        [1:0]  status_d;
	logic               last_q;
	logic               last_d;
	logic               load_out;

	assign store_word = WORD_BITS'(value_in);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] below_w;
		logic [WORD_BITS-1:0] above_w;

		if (i == 0) begin : g_first
			assign below_w = '0;
		end else begin : g_mid_lo
			assign below_w = cell_val[i-1];
		end
		if (i == DEPTH - 1) begin : g_end
			assign above_w = '0;
		end else begin : g_mid_hi
			assign above_w = cell_val[i+1];
		end

		plst_cell #(
			.WORD_BITS (WORD_BITS),
			.IDX       (i)
		) u_cell (
			.clk       (clk),
			.cmd       (cmd),
			.value_in  (store_word),
			.below     (below_w),
			.above     (above_w),
			.head      (cell_val[0]),
			.value     (cell_val[i]),
			.hit_value (cell_hit[i])
		);
	end

	// Gather the addressed cell: only the matching cell drives non-zero
	always_comb begin
		read_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			read_word = read_word | cell_hit[i];
		end
	end

	// Accept a transfer only when no traverse is streaming and the result
	// register is free or being drained this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = trav_busy_q || !out_free;
	assign accept   = in_valid && !in_stall;

	assign pos_x = XW'(position);
	assign cnt_x = XW'(count_q);

	always_comb begin
		cmd.op      = plst_pkg::CELL_HOLD;
		cmd.pos     = pos_x;
		cmd.cnt     = cnt_x;
		count_d     = count_q;
		trav_busy_d = trav_busy_q;
		trav_idx_d  = trav_idx_q;
		load_out    = 1'b0;
		value_d     = value_q;
		status_d    = status_q;
		last_d      = last_q;

		if (accept) begin
			load_out = 1'b1;
			value_d  = '0;
			status_d = plst_pkg::ST_OK;
			last_d   = 1'b1;
			unique case (action) inside
				plst_pkg::ACT_INSERT: begin
					if (count_q == CW'(DEPTH)) begin
						status_d = plst_pkg::ST_FULL;
					end else if (pos_x > cnt_x) begin
						status_d = plst_pkg::ST_RANGE;
					end else begin
						cmd.op  = plst_pkg::CELL_INSERT;
						count_d = count_q + CW'(1);
					end
				end
				plst_pkg::ACT_REMOVE, plst_pkg::ACT_READ: begin
					if (count_q == '0) begin
						status_d = plst_pkg::ST_EMPTY;
					end else if (pos_x >= cnt_x) begin
						status_d = plst_pkg::ST_RANGE;
					end else begin
						value_d = 32'($signed(read_word));
						if (action == plst_pkg::ACT_REMOVE) begin
							cmd.op  = plst_pkg::CELL_REMOVE;
							count_d = count_q - CW'(1);
						end
					end
				end
				plst_pkg::ACT_CLEAR: begin
					count_d = '0;
				end
				plst_pkg::ACT_TRAVERSE: begin
					if (count_q == '0) begin
						status_d = plst_pkg::ST_EMPTY;
					end else begin
						// Results follow once the result register is free
						load_out    = 1'b0;
						trav_busy_d = 1'b1;
						trav_idx_d  = '0;
					end
				end
				default: begin
					status_d = plst_pkg::ST_OK;
				end
			endcase
		end else if (trav_busy_q && out_free) begin
			// Stream the head and rotate the chain by one
			cmd.op     = plst_pkg::CELL_ROTATE;
			load_out   = 1'b1;
			value_d    = 32'($signed(cell_val[0]));
			status_d   = plst_pkg::ST_OK;
			last_d     = (trav_idx_q + CW'(1)) == count_q;
			trav_idx_d = trav_idx_q + CW'(1);
			if (last_d) begin
				trav_busy_d = 1'b0;
			end
		end

		if (load_out) begin
			out_valid_d = 1'b1;
		end else if (!out_stall) begin
			out_valid_d = 1'b0;
		end else begin
			out_valid_d = out_valid_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			trav_busy_q <= 1'b0;
			trav_idx_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q     <= count_d;
			trav_busy_q <= trav_busy_d;
			trav_idx_q  <= trav_idx_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Result payload: no reset needed, qualified by out_valid_q
	always_ff @(posedge clk) begin
		if (load_out) begin
			value_q  <= value_d;
			status_q <= status_d;
			last_q   <= last_d;
		end
	end

	// Entry count travels with the result it belongs to
	logic [4:0] count_out_q;
	always_ff @(posedge clk) begin
		if (load_out) begin
			count_out_q <= 5'(count_d);
		end
	end

	assign out_valid   = out_valid_q;
	assign value_out   = value_q;
	assign status      = status_q;
	assign entry_count = count_out_q;
	assign last        = last_q;

	// ------------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------------
	a_count_bound : assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_trav_nonempty : assert property (@(posedge clk) disable iff (!arst_n)
		trav_busy_q |-> (count_q != '0) && (trav_idx_q < count_q))
		else $error("traverse running past the list end");

	a_no_accept_in_trav : assert property (@(posedge clk) disable iff (!arst_n)
		trav_busy_q |-> !accept)
		else $error("transfer accepted during traverse");

	a_trav_emits : assert property (@(posedge clk) disable iff (!arst_n)
		(trav_busy_q && out_free) |=> out_valid_q)
		else $error("traverse step produced no result");

endmodule

`default_nettype wire

// File: test/tb_positional_list_store.sv
// ----------------------------------------------------------------------------
// tb_positional_list_store
// Self-checking regression for the positional list store: directed corner
// cases, then random insert/remove/read/clear/traverse traffic with bursty
// input and patterned output back-pressure, checked against a shadow list.
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
	logic signed [31:0] value;
	logic        [1:0]  status;
	logic        [4:0]  count;
	logic               last;
} list_result_t;

class list_checker;
	localparam int DEPTH = plst_pkg::DEPTH_DEFAULT;

	logic signed [31:0] words [DEPTH];
	int unsigned        held;
	list_result_t       due[$];
	int unsigned        errors;

	function new();
		held   = 0;
		errors = 0;
	endfunction

	function void add_due(logic signed [31:0] value, logic [1:0] status, logic last);
		list_result_t r;
		r.value  = value;
		r.status = status;
		r.count  = held[4:0];
		r.last   = last;
		due.push_back(r);
	endfunction

	// Apply one accepted request to the shadow list and queue its results.
	function void note_input(logic [2:0] act, logic [3:0] pos, logic signed [31:0] val);
		int unsigned        i;
		logic signed [31:0] picked;
		case (act)
		plst_pkg::ACT_INSERT: begin
			if (held >= DEPTH) begin
				add_due('0, plst_pkg::ST_FULL, 1'b1);
			end else if (pos > held) begin
				add_due('0, plst_pkg::ST_RANGE, 1'b1);
			end else begin
				for (i = held; i > pos; i--)
					words[i] = words[i-1];
				words[pos] = val;
				held++;
				add_due('0, plst_pkg::ST_OK, 1'b1);
			end
		end
		plst_pkg::ACT_REMOVE, plst_pkg::ACT_READ: begin
			if (held == 0) begin
				add_due('0, plst_pkg::ST_EMPTY, 1'b1);
			end else if (pos >= held) begin
				add_due('0, plst_pkg::ST_RANGE, 1'b1);
			end else begin
				picked = words[pos];
				if (act == plst_pkg::ACT_REMOVE) begin
					for (i = pos; i + 1 < held; i++)
						words[i] = words[i+1];
					held--;
				end
				add_due(picked, plst_pkg::ST_OK, 1'b1);
			end
		end
		plst_pkg::ACT_CLEAR: begin
			held = 0;
			add_due('0, plst_pkg::ST_OK, 1'b1);
		end
		plst_pkg::ACT_TRAVERSE: begin
			if (held == 0) begin
				add_due('0, plst_pkg::ST_EMPTY, 1'b1);
			end else begin
				for (i = 0; i < held; i++)
					add_due(words[i], plst_pkg::ST_OK, i + 1 == held);
			end
		end
		default: begin
			add_due('0, plst_pkg::ST_OK, 1'b1);
		end
		endcase
	endfunction

	function void check_result(realtime stamp, logic signed [31:0] value, logic [1:0] status,
			logic [4:0] count, logic last);
		list_result_t want;
		if (due.size() == 0) begin
			$display("%0t: unexpected result value %0d status %0d count %0d last %0b",
				stamp, value, status, count, last);
			errors++;
			return;
		end
		want = due.pop_front();
		if (value !== want.value) begin
			$display("%0t: value_out expected %0d, actual %0d", stamp, want.value, value);
			errors++;
		end
		if (status !== want.status) begin
			$display("%0t: status expected %0d, actual %0d", stamp, want.status, status);
			errors++;
		end
		if (count !== want.count) begin
			$display("%0t: entry_count expected %0d, actual %0d", stamp, want.count, count);
			errors++;
		end
		if (last !== want.last) begin
			$display("%0t: last expected %0b, actual %0b", stamp, want.last, last);
			errors++;
		end
	endfunction
endclass

module tb_positional_list_store;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int         DEPTH           = plst_pkg::DEPTH_DEFAULT;
	localparam logic [2:0] ACT_SPARE_FIRST = 3'd5;	// codes the block ignores
	localparam logic [2:0] ACT_SPARE_LAST  = 3'd7;
	localparam int         REQUEST_TARGET  = 420;	// directed and random together
	localparam int         IDLE_LIMIT      = 2000;
	localparam int         DRAIN_CYCLES    = 40;	// longest traverse plus margin

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_RUNS, STALL_HEAVY} stall_mode_t;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               in_valid    = 1'b0;
	logic               in_stall;
	logic        [2:0]  action      = '0;
	logic        [3:0]  position    = '0;
	logic signed [31:0] value_in    = '0;
	logic               out_valid;
	logic               out_stall   = 1'b0;
	logic signed [31:0] value_out;
	logic        [1:0]  status;
	logic        [4:0]  entry_count;
	logic               last;

	list_checker sb = new();

	int          requests_sent = 0;
	int          burst_left    = 0;
	int          idle_cycles   = 0;
	stall_mode_t stall_mode    = STALL_NONE;
	int          mode_left     = 0;
	int          stall_run     = 0;
	logic        hold_stall    = 1'b0;

	positional_list_store i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.action      (action),
		.position    (position),
		.value_in    (value_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value_out   (value_out),
		.status      (status),
		.entry_count (entry_count),
		.last        (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Present one request and hold it until the transfer happens. The sender
	// works in bursts: between bursts, drop valid for a random gap (often none,
	// so long stretches run back to back).
	task automatic send_request(input logic [2:0] act, input logic [3:0] pos,
			input logic signed [31:0] val);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		in_valid <= 1'b1;
		action   <= act;
		position <= pos;
		value_in <= val;
		// Hold the payload steady while stalled
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_input(act, pos, val);
		requests_sent++;
	endtask

	// Favour the signed extremes and zero, otherwise any 32-bit pattern
	function automatic logic signed [31:0] pick_word();
		case ($urandom_range(0, 9))
		0:       return 32'sh0000_0000;
		1:       return 32'shFFFF_FFFF;
		2:       return 32'sh7FFF_FFFF;
		3:       return 32'sh8000_0000;
		default: return $urandom;
		endcase
	endfunction

	// Mostly positions within or just past the list, sometimes anything
	function automatic logic [3:0] pick_position();
		if ($urandom_range(0, 9) < 7)
			return 4'($urandom_range(0, (sb.held > 15) ? 15 : sb.held));
		return 4'($urandom);
	endfunction

	function automatic logic [2:0] pick_action();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 32)      return plst_pkg::ACT_INSERT;
		else if (roll < 52) return plst_pkg::ACT_REMOVE;
		else if (roll < 72) return plst_pkg::ACT_READ;
		else if (roll < 77) return plst_pkg::ACT_CLEAR;
		else if (roll < 91) return plst_pkg::ACT_TRAVERSE;
		return 3'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
	endfunction

	// Result monitor, idle watchdog and receiver back-pressure. Sample before
	// the stall update so every check sees the values settled before the edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_result($realtime, value_out, status, entry_count, last);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("positional_list_store regression: fail");
				$finish;
			end
		end

		// Pick a new stall pattern once the current one has run its random length
		if (mode_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			mode_left  = $urandom_range(50, 300);
		end else begin
			mode_left--;
		end
		case (stall_mode)
		STALL_NONE:  out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_RUNS: begin
			// Alternate runs of stall and release
			if (stall_run == 0) begin
				hold_stall = !hold_stall;
				stall_run  = hold_stall ? $urandom_range(1, 8) : $urandom_range(1, 4);
			end else begin
				stall_run--;
			end
			out_stall <= hold_stall;
		end
		default:     out_stall <= ($urandom_range(0, 2) != 0);
		endcase
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty-list cases first
		send_request(plst_pkg::ACT_TRAVERSE, 4'd0, 32'sd0);
		send_request(plst_pkg::ACT_REMOVE, 4'd0, 32'sd0);
		send_request(plst_pkg::ACT_READ, 4'd15, 32'sd0);
		send_request(plst_pkg::ACT_INSERT, 4'd1, 32'sd5);	// past the end of an empty list
		// Build [-1, max, 0, min] through front, middle and append inserts
		send_request(plst_pkg::ACT_INSERT, 4'd0, 32'sh7FFF_FFFF);
		send_request(plst_pkg::ACT_INSERT, 4'd1, 32'sh8000_0000);
		send_request(plst_pkg::ACT_INSERT, 4'd0, 32'shFFFF_FFFF);
		send_request(plst_pkg::ACT_INSERT, 4'd2, 32'sh0000_0000);
		send_request(plst_pkg::ACT_INSERT, 4'd15, 32'sd7);	// far past the end
		send_request(plst_pkg::ACT_READ, 4'd4, 32'sd0);		// one past the last entry
		send_request(plst_pkg::ACT_READ, 4'd3, 32'sd0);
		send_request(plst_pkg::ACT_READ, 4'd0, 32'sd0);
		send_request(plst_pkg::ACT_REMOVE, 4'd15, 32'sd0);
		send_request(plst_pkg::ACT_REMOVE, 4'd1, 32'sd0);
		send_request(plst_pkg::ACT_TRAVERSE, 4'd0, 32'sd0);
		for (int a = ACT_SPARE_FIRST; a <= ACT_SPARE_LAST; a++)
			send_request(3'(a), 4'($urandom), $urandom);
		send_request(plst_pkg::ACT_REMOVE, 4'd2, 32'sd0);	// remove the last entry
		send_request(plst_pkg::ACT_CLEAR, 4'd9, 32'sd0);
		send_request(plst_pkg::ACT_TRAVERSE, 4'd0, 32'sd0);
		send_request(plst_pkg::ACT_READ, 4'd0, 32'sd0);

		// Random: fill-to-full and drain-to-empty sequences, mixed with noise
		while (requests_sent < REQUEST_TARGET) begin
			case ($urandom_range(0, 9))
			0, 1, 2: begin
				while (sb.held < DEPTH)
					send_request(plst_pkg::ACT_INSERT,
						4'($urandom_range(0, sb.held)), pick_word());
				repeat ($urandom_range(1, 2))
					send_request(plst_pkg::ACT_INSERT, 4'($urandom), pick_word());
				send_request(plst_pkg::ACT_TRAVERSE, 4'($urandom), $urandom);
			end
			3, 4: begin
				while (sb.held > 0) begin
					if ($urandom_range(0, 3) == 0)
						send_request(plst_pkg::ACT_READ,
							4'($urandom_range(0, sb.held - 1)), $urandom);
					else
						send_request(plst_pkg::ACT_REMOVE,
							4'($urandom_range(0, sb.held - 1)), $urandom);
				end
				send_request(plst_pkg::ACT_REMOVE, 4'($urandom), $urandom);
				send_request(plst_pkg::ACT_TRAVERSE, 4'($urandom), $urandom);
			end
			default: begin
				repeat ($urandom_range(8, 24))
					send_request(pick_action(), pick_position(), pick_word());
			end
			endcase
		end
		in_valid <= 1'b0;

		// Let every outstanding result arrive, then watch for strays
		while (sb.due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0 && sb.due.size() == 0)
			$display("positional_list_store regression: pass");
		else
			$display("positional_list_store regression: fail");
		$finish;
	end

endmodule

`default_nettype wire
